>>> rtl/core/rps_pkg.sv
package rps_pkg;

    // Image geometry
    localparam int IMAGE_WIDTH  = 32;
    localparam int IMAGE_HEIGHT = 32;
    localparam int COORD_W      = 5;
    localparam int COORD_N      = 1 << COORD_W;
    localparam int NCH          = 3;

    // Number formats
    localparam int QW         = 24;
    localparam int FRAC_W     = 20;
    localparam int RAD_W      = 40;
    localparam int ROOT_W     = 20;
    localparam int DIV_W      = 21;
    localparam int SQRT_STEPS = RAD_W / 2;
    localparam int GLOW_STEPS = 8;
    localparam int GLOW_REM_W = 22;
    localparam int GLOW_CMP_W = ROOT_W + GLOW_STEPS;

    typedef logic signed [QW-1:0] q_t;
    typedef logic [15:0]          phase_t;
    typedef logic [RAD_W-1:0]     rad_t;
    typedef logic [ROOT_W-1:0]    root_t;
    typedef logic signed [21:0]   sine_t;
    typedef logic [21:0]          scale_t;
    typedef logic [DIV_W-1:0]     quo_t;
    typedef logic [7:0]           chan_t;

    localparam longint Q_HALF_L = 524288;
    localparam longint Q_MAX_L  = 8388607;
    localparam longint Q_MIN_L  = -8388608;

    localparam logic [31:0] TIME_STEP   = 32'd68356528;
    localparam logic [31:0] TIME_ROUND  = 32'h0000_8000;
    localparam phase_t      CHAN_STEP   = 16'd730;
    localparam logic [12:0] RIPPLE_FREQ = 13'd5867;
    localparam root_t       DIST_EPS    = 20'd105;
    localparam int          GLOW_NUM_I  = 2673869;
    localparam logic [GLOW_REM_W-1:0] GLOW_NUM = GLOW_REM_W'(GLOW_NUM_I);
    // largest distance for which the quotient exceeds the 8-bit channel range
    localparam root_t GLOW_SAT_D = ROOT_W'(GLOW_NUM_I / (1 << GLOW_STEPS));
    localparam chan_t CHAN_MAX   = 8'd255;

    localparam logic [20:0] QSINE [17] = '{
        21'd0,      21'd102778, 21'd204567, 21'd304386, 21'd401273, 21'd494295,
        21'd582558, 21'd665210, 21'd741455, 21'd810560, 21'd871859, 21'd924762,
        21'd968758, 21'd1003425, 21'd1028428, 21'd1043526, 21'd1048576
    };

    typedef struct packed {
        q_t                  uvx;
        q_t                  uvy;
        q_t                  px;
        q_t                  py;
        root_t               l;
        phase_t [NCH-1:0]    z;
    } pix_t;

    typedef struct packed {
        q_t [NCH-1:0] ux;
        q_t [NCH-1:0] uy;
    } warp_t;

    typedef struct packed {
        rad_t rem;
        rad_t root;
    } sqrt_t;

    typedef struct packed {
        rad_t rem;
        quo_t quo;
    } div_t;

    typedef struct packed {
        logic [GLOW_REM_W-1:0] rem;
        logic [GLOW_STEPS-1:0] quo;
    } gdiv_t;

    typedef q_t   q_tab_t [COORD_N];
    typedef rad_t sq_tab_t [COORD_N];

    function automatic q_t sat_q(input longint v);
        q_t r;
        if (v > Q_MAX_L)
            r = q_t'(Q_MAX_L);
        else if (v < Q_MIN_L)
            r = q_t'(Q_MIN_L);
        else
            r = q_t'(v);
        return r;
    endfunction

    function automatic q_tab_t build_uv_x();
        q_tab_t t;
        for (int i = 0; i < COORD_N; i++)
            t[i] = sat_q((longint'(i) <<< FRAC_W) / (IMAGE_WIDTH - 1));
        return t;
    endfunction

    function automatic q_tab_t build_uv_y();
        q_tab_t t;
        for (int i = 0; i < COORD_N; i++)
            t[i] = sat_q((longint'(i) <<< FRAC_W) / (IMAGE_HEIGHT - 1));
        return t;
    endfunction

    function automatic q_tab_t build_p_x(input q_tab_t uv);
        q_tab_t t;
        for (int i = 0; i < COORD_N; i++)
            t[i] = sat_q(((longint'(uv[i]) - Q_HALF_L) * IMAGE_WIDTH) / IMAGE_HEIGHT);
        return t;
    endfunction

    function automatic q_tab_t build_p_y(input q_tab_t uv);
        q_tab_t t;
        for (int i = 0; i < COORD_N; i++)
            t[i] = sat_q(longint'(uv[i]) - Q_HALF_L);
        return t;
    endfunction

    function automatic sq_tab_t build_sq(input q_tab_t p);
        sq_tab_t t;
        for (int i = 0; i < COORD_N; i++)
            t[i] = rad_t'(longint'(p[i]) * longint'(p[i]));
        return t;
    endfunction

    localparam q_tab_t  UV_X  = build_uv_x();
    localparam q_tab_t  UV_Y  = build_uv_y();
    localparam q_tab_t  P_X   = build_p_x(UV_X);
    localparam q_tab_t  P_Y   = build_p_y(UV_Y);
    localparam sq_tab_t PX_SQ = build_sq(P_X);
    localparam sq_tab_t PY_SQ = build_sq(P_Y);

    // quarter-wave sine, Q20, linear interpolation over 10 fraction bits
    function automatic sine_t sine_q(input phase_t ph);
        logic [1:0]  quad;
        logic [14:0] pos;
        logic [4:0]  idx;
        logic [9:0]  frac;
        logic [20:0] diff;
        logic [30:0] prod;
        logic [20:0] mag;
        quad = ph[15:14];
        pos  = {1'b0, ph[13:0]};
        if (quad[0])
            pos = 15'h4000 - pos;
        idx  = pos[14:10];
        frac = pos[9:0];
        if (idx >= 5'd16)
        begin
            mag = QSINE[16];
        end
        else
        begin
            diff = QSINE[idx + 5'd1] - QSINE[idx];
            prod = 31'(diff) * 31'(frac);
            mag  = QSINE[idx] + prod[30:10];
        end
        return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    // one digit of the square-root recurrence
    function automatic sqrt_t sqrt_step(input sqrt_t s, input int step);
        logic [RAD_W:0] trial;
        rad_t           bit_w;
        sqrt_t          n;
        bit_w = rad_t'(1) << (RAD_W - 2 - 2 * step);
        trial = {1'b0, s.root} + {1'b0, bit_w};
        if ({1'b0, s.rem} >= trial)
        begin
            n.rem  = s.rem - trial[RAD_W-1:0];
            n.root = (s.root >> 1) + bit_w;
        end
        else
        begin
            n.rem  = s.rem;
            n.root = s.root >> 1;
        end
        return n;
    endfunction

    // one quotient bit of restoring division
    function automatic div_t div_step(input div_t s, input root_t den, input int step);
        rad_t den_sh;
        div_t n;
        den_sh = rad_t'(den) << (DIV_W - 1 - step);
        n      = s;
        if (s.rem >= den_sh)
        begin
            n.rem                  = s.rem - den_sh;
            n.quo[DIV_W-1-step]    = 1'b1;
        end
        return n;
    endfunction

    function automatic gdiv_t glow_step(input gdiv_t s, input root_t den, input int step);
        logic [GLOW_CMP_W-1:0] den_sh;
        logic [GLOW_CMP_W-1:0] rem_w;
        gdiv_t                 n;
        den_sh = GLOW_CMP_W'(den) << (GLOW_STEPS - 1 - step);
        rem_w  = GLOW_CMP_W'(s.rem);
        n      = s;
        if (rem_w >= den_sh)
        begin
            n.rem                     = GLOW_REM_W'(rem_w - den_sh);
            n.quo[GLOW_STEPS-1-step]  = 1'b1;
        end
        return n;
    endfunction

    function automatic q_t sat_add(input q_t base, input logic [22:0] mag, input logic neg);
        logic signed [25:0] s;
        q_t                 r;
        s = neg ? 26'(base) - $signed({3'b000, mag}) : 26'(base) + $signed({3'b000, mag});
        if (s > 26'sd8388607)
            r = q_t'(Q_MAX_L);
        else if (s < -26'sd8388608)
            r = q_t'(Q_MIN_L);
        else
            r = s[QW-1:0];
        return r;
    endfunction

endpackage

>>> rtl/core/rps_front.sv
module rps_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [rps_pkg::COORD_W-1:0] column,
    input  logic [rps_pkg::COORD_W-1:0] row,
    input  logic [15:0]                 frame_number,
    output logic                        out_valid,
    output rps_pkg::pix_t               pix
);
    import rps_pkg::*;

    logic                  v0_reg;
    q_t                    uvx0_reg;
    q_t                    uvy0_reg;
    q_t                    px0_reg;
    q_t                    py0_reg;
    rad_t                  rad0_reg;
    logic [31:0]           tprod0_reg;
    logic [SQRT_STEPS-1:0] vld_reg;
    sqrt_t                 sq_reg [SQRT_STEPS];
    pix_t                  side_reg [SQRT_STEPS];
    pix_t                  side0;
    sqrt_t                 sq0;
    phase_t                tph;

    always_comb
    begin
        tph       = phase_t'((tprod0_reg + TIME_ROUND) >> 16);
        side0.uvx = uvx0_reg;
        side0.uvy = uvy0_reg;
        side0.px  = px0_reg;
        side0.py  = py0_reg;
        side0.l   = '0;
        for (int k = 0; k < NCH; k++)
            side0.z[k] = tph + phase_t'(int'(CHAN_STEP) * (k + 1));
        sq0.rem  = rad0_reg;
        sq0.root = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg  <= 1'b0;
            vld_reg <= '0;
        end
        else if (en)
        begin
            v0_reg  <= in_valid;
            vld_reg <= {vld_reg[SQRT_STEPS-2:0], v0_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            uvx0_reg    <= UV_X[column];
            uvy0_reg    <= UV_Y[row];
            px0_reg     <= P_X[column];
            py0_reg     <= P_Y[row];
            rad0_reg    <= PX_SQ[column] + PY_SQ[row];
            tprod0_reg  <= TIME_STEP * {16'd0, frame_number};
            sq_reg[0]   <= sqrt_step(sq0, 0);
            side_reg[0] <= side0;
            for (int i = 1; i < SQRT_STEPS; i++)
            begin
                sq_reg[i]   <= sqrt_step(sq_reg[i-1], i);
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    always_comb
    begin
        pix       = side_reg[SQRT_STEPS-1];
        pix.l     = sq_reg[SQRT_STEPS-1].root[ROOT_W-1:0];
        out_valid = vld_reg[SQRT_STEPS-1];
    end

endmodule

>>> rtl/core/rps_ripple.sv
module rps_ripple
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  rps_pkg::pix_t  pix,
    output logic           out_valid,
    output rps_pkg::warp_t warp
);
    import rps_pkg::*;

    typedef struct packed {
        quo_t dxm;
        quo_t dym;
        logic sx;
        logic sy;
        q_t   uvx;
        q_t   uvy;
        logic ok;
    } disp_t;

    logic [DIV_W-1:0] dvld_reg;
    div_t             dx_reg [DIV_W];
    div_t             dy_reg [DIV_W];
    pix_t             rp_reg [DIV_W];
    div_t             dx0;
    div_t             dy0;
    logic [QW-1:0]    absx;
    logic [QW-1:0]    absy;

    logic [4:0]       pvld_reg;
    disp_t            a_reg;
    disp_t            b_reg;
    disp_t            c_reg;
    disp_t            d_reg;
    phase_t           a_arg_reg [NCH];
    sine_t            a_sz_reg [NCH];
    logic [20:0]      b_sa_reg [NCH];
    scale_t           b_sz1_reg [NCH];
    scale_t           c_scale_reg [NCH];
    logic [42:0]      d_px_reg [NCH];
    logic [42:0]      d_py_reg [NCH];
    warp_t            e_reg;

    pix_t             last;
    disp_t            a_next;
    logic [32:0]      plw;
    phase_t           pl;
    sine_t            sa_s [NCH];
    logic [22:0]      sz_ext [NCH];
    logic [42:0]      sc_prod [NCH];

    always_comb
    begin
        absx    = pix.px[QW-1] ? QW'(-pix.px) : pix.px;
        absy    = pix.py[QW-1] ? QW'(-pix.py) : pix.py;
        dx0.rem = rad_t'(absx) << FRAC_W;
        dx0.quo = '0;
        dy0.rem = rad_t'(absy) << FRAC_W;
        dy0.quo = '0;

        last       = rp_reg[DIV_W-1];
        plw        = 33'(last.l) * 33'(RIPPLE_FREQ);
        pl         = plw[31:16];
        a_next.dxm = dx_reg[DIV_W-1].quo;
        a_next.dym = dy_reg[DIV_W-1].quo;
        a_next.sx  = last.px[QW-1];
        a_next.sy  = last.py[QW-1];
        a_next.uvx = last.uvx;
        a_next.uvy = last.uvy;
        a_next.ok  = (last.l >= DIST_EPS);

        for (int k = 0; k < NCH; k++)
        begin
            sa_s[k]    = sine_q(a_arg_reg[k]);
            sz_ext[k]  = {a_sz_reg[k][21], a_sz_reg[k]} + 23'd1048576;
            sc_prod[k] = 43'(b_sz1_reg[k]) * 43'(b_sa_reg[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dvld_reg <= '0;
            pvld_reg <= '0;
        end
        else if (en)
        begin
            dvld_reg <= {dvld_reg[DIV_W-2:0], in_valid};
            pvld_reg <= {pvld_reg[3:0], dvld_reg[DIV_W-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg[0] <= div_step(dx0, pix.l, 0);
            dy_reg[0] <= div_step(dy0, pix.l, 0);
            rp_reg[0] <= pix;
            for (int i = 1; i < DIV_W; i++)
            begin
                dx_reg[i] <= div_step(dx_reg[i-1], rp_reg[i-1].l, i);
                dy_reg[i] <= div_step(dy_reg[i-1], rp_reg[i-1].l, i);
                rp_reg[i] <= rp_reg[i-1];
            end

            a_reg <= a_next;
            b_reg <= a_reg;
            c_reg <= b_reg;
            d_reg <= c_reg;
            for (int k = 0; k < NCH; k++)
            begin
                // arg = 9 l - 2 z
                a_arg_reg[k]   <= pl - {last.z[k][14:0], 1'b0};
                a_sz_reg[k]    <= sine_q(last.z[k]);
                b_sa_reg[k]    <= 21'(sa_s[k][21] ? -sa_s[k] : sa_s[k]);
                b_sz1_reg[k]   <= sz_ext[k][21:0];
                c_scale_reg[k] <= sc_prod[k][41:20];
                d_px_reg[k]    <= 43'(c_reg.dxm) * 43'(c_scale_reg[k]);
                d_py_reg[k]    <= 43'(c_reg.dym) * 43'(c_scale_reg[k]);
                e_reg.ux[k]    <= sat_add(d_reg.uvx, d_reg.ok ? d_px_reg[k][42:20] : 23'd0,
                                          d_reg.sx);
                e_reg.uy[k]    <= sat_add(d_reg.uvy, d_reg.ok ? d_py_reg[k][42:20] : 23'd0,
                                          d_reg.sy);
            end
        end
    end

    assign out_valid = pvld_reg[4];
    assign warp      = e_reg;

endmodule

>>> rtl/core/rps_glow.sv
module rps_glow
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  rps_pkg::warp_t                  warp,
    output logic                            out_valid,
    output rps_pkg::chan_t [rps_pkg::NCH-1:0] color
);
    import rps_pkg::*;

    localparam int GV_N = 3 + SQRT_STEPS + GLOW_STEPS;

    logic [GV_N-1:0]    gv_reg;
    logic signed [20:0] mx_reg [NCH];
    logic signed [20:0] my_reg [NCH];
    rad_t               sqx_reg [NCH];
    rad_t               sqy_reg [NCH];
    rad_t               sum_reg [NCH];
    sqrt_t              gsq_reg [SQRT_STEPS][NCH];
    gdiv_t              gq_reg [GLOW_STEPS][NCH];
    root_t              den_reg [GLOW_STEPS][NCH];
    logic               zero_reg [GLOW_STEPS][NCH];
    logic               sat_reg [GLOW_STEPS][NCH];

    logic signed [41:0] sqx_full [NCH];
    logic signed [41:0] sqy_full [NCH];
    sqrt_t              gsq0 [NCH];
    gdiv_t              gq0;
    root_t              d_last [NCH];

    always_comb
    begin
        gq0.rem = GLOW_NUM;
        gq0.quo = '0;
        for (int k = 0; k < NCH; k++)
        begin
            sqx_full[k]  = mx_reg[k] * mx_reg[k];
            sqy_full[k]  = my_reg[k] * my_reg[k];
            gsq0[k].rem  = sum_reg[k];
            gsq0[k].root = '0;
            d_last[k]    = gsq_reg[SQRT_STEPS-1][k].root[ROOT_W-1:0];
            if (zero_reg[GLOW_STEPS-1][k])
                color[k] = '0;
            else if (sat_reg[GLOW_STEPS-1][k])
                color[k] = CHAN_MAX;
            else
                color[k] = gq_reg[GLOW_STEPS-1][k].quo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gv_reg <= '0;
        else if (en)
            gv_reg <= {gv_reg[GV_N-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NCH; k++)
            begin
                // offset to nearest cell centre: low 20 bits minus one half
                mx_reg[k]     <= $signed({1'b0, warp.ux[k][FRAC_W-1:0]}) - 21'sd524288;
                my_reg[k]     <= $signed({1'b0, warp.uy[k][FRAC_W-1:0]}) - 21'sd524288;
                sqx_reg[k]    <= sqx_full[k][RAD_W-1:0];
                sqy_reg[k]    <= sqy_full[k][RAD_W-1:0];
                sum_reg[k]    <= sqx_reg[k] + sqy_reg[k];
                gsq_reg[0][k] <= sqrt_step(gsq0[k], 0);
                for (int i = 1; i < SQRT_STEPS; i++)
                    gsq_reg[i][k] <= sqrt_step(gsq_reg[i-1][k], i);

                gq_reg[0][k]   <= glow_step(gq0, d_last[k], 0);
                den_reg[0][k]  <= d_last[k];
                zero_reg[0][k] <= (d_last[k] < DIST_EPS);
                sat_reg[0][k]  <= (d_last[k] <= GLOW_SAT_D);
                for (int i = 1; i < GLOW_STEPS; i++)
                begin
                    gq_reg[i][k]   <= glow_step(gq_reg[i-1][k], den_reg[i-1][k], i);
                    den_reg[i][k]  <= den_reg[i-1][k];
                    zero_reg[i][k] <= zero_reg[i-1][k];
                    sat_reg[i][k]  <= sat_reg[i-1][k];
                end
            end
        end
    end

    assign out_valid = gv_reg[GV_N-1];

endmodule

>>> rtl/core/procedural_ripple_pixel_shader_core.sv
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_ready  column[5], row[5], frame_number[16]
// out      output     out_valid/out_ready red[8], green[8], blue[8]
//
// One item per cycle sustained, unless output backpressure stalls the pipeline.
// Latency is set by three digit-serial chains: the 20-step root of the centre
// distance, the 21-step displacement divide and the 20-step cell-distance root
// plus an 8-step glow divide, one digit per stage.
// rst_n clears only the valid bits; the data path carries no reset.
// A stall freezes the whole pipeline at once: in_ready drops only while a
// result sits in the output register and out_ready is low.
module procedural_ripple_pixel_shader_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [rps_pkg::COORD_W-1:0] column,
    input  logic [rps_pkg::COORD_W-1:0] row,
    input  logic [15:0]                 frame_number,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  red,
    output logic [7:0]                  green,
    output logic [7:0]                  blue
);
    import rps_pkg::*;

    logic               en;
    logic               front_vld;
    pix_t               front_pix;
    logic               rip_vld;
    warp_t              rip_warp;
    logic               glow_vld;
    chan_t [NCH-1:0]    glow_color;

    logic               out_valid_reg;
    chan_t              red_reg;
    chan_t              green_reg;
    chan_t              blue_reg;

    // the whole pipeline advances together unless the output item is blocked
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // pixel setup, time phase and centre distance
    rps_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (in_valid),
        .column       (column),
        .row          (row),
        .frame_number (frame_number),
        .out_valid    (front_vld),
        .pix          (front_pix)
    );

    // radial push of the coordinate, per channel
    rps_ripple u_ripple
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_vld),
        .pix       (front_pix),
        .out_valid (rip_vld),
        .warp      (rip_warp)
    );

    // inverse distance to cell centre, saturated
    rps_glow u_glow
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rip_vld),
        .warp      (rip_warp),
        .out_valid (glow_vld),
        .color     (glow_color)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= glow_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            red_reg   <= glow_color[0];
            green_reg <= glow_color[1];
            blue_reg  <= glow_color[2];
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

`ifndef SYNTHESIS
    a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    a_stall_freezes_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |=> glow_vld == $past(glow_vld))
        else $error("pipeline moved during a stall");

    a_result_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        glow_vld && in_ready |=> out_valid)
        else $error("finished item lost before the output register");
`endif

endmodule
